// ===== design/cau_pkg.sv =====
// Shared types and codes for the complex arithmetic unit.
package cau_pkg;

    localparam int DATA_WIDTH = 32;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic [1:0]                   operation;
        logic signed [DATA_WIDTH-1:0] a_real;
        logic signed [DATA_WIDTH-1:0] a_imag;
        logic signed [DATA_WIDTH-1:0] b_real;
        logic signed [DATA_WIDTH-1:0] b_imag;
    } t_cau_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_real;
        logic signed [DATA_WIDTH-1:0] result_imag;
        logic [1:0]                   status;
    } t_cau_out;

endpackage

// ===== design/complex_arithmetic_unit.sv =====
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// Operands pass through the product, combine and magnitude stages, then the
// restoring divider that produces one quotient bit per pipeline stage.
// Throughput: one transaction per cycle for every operation; busy stays low.
// Reset clears the valid bits of every stage; the datapath registers keep data.
// The result strobe cannot be held off by the receiver.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cau_pkg::t_cau_in  i_in,
    output logic              o_valid,
    output cau_pkg::t_cau_out o_result
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;        // product width
    localparam int SW = 2 * W + 1;    // signed sum of two products
    localparam int MW = 2 * W;        // magnitude of such a sum
    localparam int DW = 2 * W;        // squared magnitude of the divisor
    localparam int QW = MW + FRAC_BITS;

    localparam logic [QW-1:0] POS_LIM = QW'({1'b0, {(W-1){1'b1}}});
    localparam logic [QW-1:0] NEG_LIM = QW'({1'b1, {(W-1){1'b0}}});

    typedef struct packed {
        logic            div;
        logic            dz;
        logic            neg_r;
        logic            neg_i;
        logic [DW-1:0]   den;
        logic [DW-1:0]   rem_r;
        logic [QW-1:0]   num_r;
        logic [QW-1:0]   q_r;
        logic [DW-1:0]   rem_i;
        logic [QW-1:0]   num_i;
        logic [QW-1:0]   q_i;
    } t_dstage;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage 1: products and the add/subtract sums.
    logic                 r_v1;
    logic [1:0]           r_op1;
    logic                 r_dz1;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_jj;
    logic signed [W:0]    r_s_re, r_s_im;
    logic signed [W:0]    n_s_re, n_s_im;

    always_comb begin
        if (i_in.operation == OP_SUB) begin
            n_s_re = (W+1)'(i_in.a_real) - (W+1)'(i_in.b_real);
            n_s_im = (W+1)'(i_in.a_imag) - (W+1)'(i_in.b_imag);
        end else begin
            n_s_re = (W+1)'(i_in.a_real) + (W+1)'(i_in.b_real);
            n_s_im = (W+1)'(i_in.a_imag) + (W+1)'(i_in.b_imag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
        r_op1  <= i_in.operation;
        r_dz1  <= (i_in.b_real == '0) && (i_in.b_imag == '0);
        r_p_rr <= PW'(i_in.a_real) * PW'(i_in.b_real);
        r_p_ii <= PW'(i_in.a_imag) * PW'(i_in.b_imag);
        r_p_ri <= PW'(i_in.a_real) * PW'(i_in.b_imag);
        r_p_ir <= PW'(i_in.a_imag) * PW'(i_in.b_real);
        r_p_bb <= PW'(i_in.b_real) * PW'(i_in.b_real);
        r_p_jj <= PW'(i_in.b_imag) * PW'(i_in.b_imag);
        r_s_re <= n_s_re;
        r_s_im <= n_s_im;
    end

    // Stage 2: combine products into the numerators and the divisor.
    logic                 r_v2;
    logic [1:0]           r_op2;
    logic                 r_dz2;
    logic signed [SW-1:0] r_num_r, r_num_i;
    logic [DW-1:0]        r_den2;
    logic signed [SW-1:0] n_num_r, n_num_i;

    always_comb begin
        case (r_op1)
            OP_MUL: begin
                n_num_r = SW'(r_p_rr) - SW'(r_p_ii);
                n_num_i = SW'(r_p_ri) + SW'(r_p_ir);
            end
            OP_DIV: begin
                n_num_r = SW'(r_p_rr) + SW'(r_p_ii);
                n_num_i = SW'(r_p_ir) - SW'(r_p_ri);
            end
            default: begin
                n_num_r = SW'(r_s_re);
                n_num_i = SW'(r_s_im);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_op2   <= r_op1;
        r_dz2   <= r_dz1;
        r_num_r <= n_num_r;
        r_num_i <= n_num_i;
        r_den2  <= DW'(r_p_bb) + DW'(r_p_jj);
    end

    // Stage 3: sign and magnitude.
    logic          r_v3;
    logic [1:0]    r_op3;
    logic          r_dz3;
    logic          r_neg_r3, r_neg_i3;
    logic [MW-1:0] r_mag_r3, r_mag_i3;
    logic [DW-1:0] r_den3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_op3    <= r_op2;
        r_dz3    <= r_dz2;
        r_den3   <= r_den2;
        r_neg_r3 <= r_num_r[SW-1];
        r_neg_i3 <= r_num_i[SW-1];
        r_mag_r3 <= r_num_r[SW-1] ? MW'(-r_num_r) : MW'(r_num_r);
        r_mag_i3 <= r_num_i[SW-1] ? MW'(-r_num_i) : MW'(r_num_i);
    end

    // Divider entry. For other operations the quotient field carries the
    // finished magnitude through the divider stages unchanged.
    t_dstage d_in;
    always_comb begin
        d_in.div   = (r_op3 == OP_DIV);
        d_in.dz    = r_dz3 && (r_op3 == OP_DIV);
        d_in.neg_r = r_neg_r3;
        d_in.neg_i = r_neg_i3;
        d_in.den   = r_den3;
        d_in.rem_r = '0;
        d_in.rem_i = '0;
        d_in.num_r = QW'(r_mag_r3) << FRAC_BITS;
        d_in.num_i = QW'(r_mag_i3) << FRAC_BITS;
        if (r_op3 == OP_MUL) begin
            d_in.q_r = QW'(r_mag_r3 >> FRAC_BITS);
            d_in.q_i = QW'(r_mag_i3 >> FRAC_BITS);
        end else if (r_op3 == OP_DIV) begin
            d_in.q_r = '0;
            d_in.q_i = '0;
        end else begin
            d_in.q_r = QW'(r_mag_r3);
            d_in.q_i = QW'(r_mag_i3);
        end
    end

    // Restoring divider: one quotient bit of each part per stage.
    t_dstage       r_d  [QW];
    logic [QW-1:0] r_dv;

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_div
            t_dstage       prev;
            t_dstage       n_d;
            logic          prev_v;
            logic [DW:0]   t_r, t_i;
            logic          ge_r, ge_i;

            if (k == 0) begin : g_first
                assign prev   = d_in;
                assign prev_v = r_v3;
            end else begin : g_rest
                assign prev   = r_d[k-1];
                assign prev_v = r_dv[k-1];
            end

            always_comb begin
                t_r  = {prev.rem_r, prev.num_r[QW-1]};
                t_i  = {prev.rem_i, prev.num_i[QW-1]};
                ge_r = t_r >= {1'b0, prev.den};
                ge_i = t_i >= {1'b0, prev.den};
                n_d  = prev;
                if (prev.div) begin
                    n_d.rem_r = ge_r ? DW'(t_r - {1'b0, prev.den}) : t_r[DW-1:0];
                    n_d.rem_i = ge_i ? DW'(t_i - {1'b0, prev.den}) : t_i[DW-1:0];
                    n_d.num_r = prev.num_r << 1;
                    n_d.num_i = prev.num_i << 1;
                    n_d.q_r   = {prev.q_r[QW-2:0], ge_r};
                    n_d.q_i   = {prev.q_i[QW-2:0], ge_i};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[k] <= 1'b0;
                end else begin
                    r_dv[k] <= prev_v;
                end
                r_d[k] <= n_d;
            end
        end
    endgenerate

    // Output stage: saturation and status.
    t_dstage  last;
    t_cau_out n_out;
    logic     sat_r, sat_i;

    always_comb begin
        last  = r_d[QW-1];
        sat_r = last.neg_r ? (last.q_r > NEG_LIM) : (last.q_r > POS_LIM);
        sat_i = last.neg_i ? (last.q_i > NEG_LIM) : (last.q_i > POS_LIM);
        if (sat_r) begin
            n_out.result_real = last.neg_r ? W'(NEG_LIM) : W'(POS_LIM);
        end else begin
            n_out.result_real = last.neg_r ? -W'(last.q_r) : W'(last.q_r);
        end
        if (sat_i) begin
            n_out.result_imag = last.neg_i ? W'(NEG_LIM) : W'(POS_LIM);
        end else begin
            n_out.result_imag = last.neg_i ? -W'(last.q_i) : W'(last.q_i);
        end
        n_out.status = (sat_r || sat_i) ? ST_SAT : ST_OK;
        if (last.dz) begin
            n_out.result_real = '0;
            n_out.result_imag = '0;
            n_out.status      = ST_DIVZ;
        end
    end

    t_cau_out r_out;
    logic     r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_dv[QW-1];
        end
        r_out <= n_out;
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;

endmodule

// ===== test/tb_complex_arithmetic_unit.sv =====
// Testbench for the complex arithmetic unit: directed and random transactions checked in order.
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 2 * DATA_WIDTH + FRAC + 4;
    localparam longint MAX_CYCLES = 400000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_cau_in  i_in = '0;
    logic     o_valid;
    t_cau_out o_result;

    t_cau_out expected_results[$];
    int       n_errors = 0;
    longint   cycle_count = 0;

    complex_arithmetic_unit #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_valid(o_valid), .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Clamp an exact value to the signed word range and flag saturation.
    function automatic logic [DATA_WIDTH-1:0] clamp_word(input logic signed [127:0] v,
                                                        inout logic sat);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        hi_lim = (128'sd1 <<< (DATA_WIDTH - 1)) - 1;
        lo_lim = -(128'sd1 <<< (DATA_WIDTH - 1));
        if (v > hi_lim) begin
            sat = 1'b1;
            return hi_lim[DATA_WIDTH-1:0];
        end
        if (v < lo_lim) begin
            sat = 1'b1;
            return lo_lim[DATA_WIDTH-1:0];
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    // Shift or divide with truncation toward zero on the magnitude.
    function automatic logic signed [127:0] trunc_div(input logic signed [127:0] num,
                                                     input logic signed [127:0] den);
        logic neg;
        logic [127:0] mag;
        neg = num < 0;
        mag = neg ? -num : num;
        mag = (mag << FRAC) / den;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [127:0] trunc_shift(input logic signed [127:0] v);
        logic [127:0] mag;
        mag = (v < 0) ? -v : v;
        mag = mag >> FRAC;
        return (v < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic t_cau_out complex_result(input t_cau_in x);
        t_cau_out r;
        logic sat;
        logic signed [127:0] ar, ai, br, bi, re, im, den;
        ar = x.a_real;
        ai = x.a_imag;
        br = x.b_real;
        bi = x.b_imag;
        sat = 1'b0;
        case (x.operation)
            OP_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL: begin
                re = trunc_shift(ar * br - ai * bi);
                im = trunc_shift(ar * bi + br * ai);
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.result_real = '0;
                    r.result_imag = '0;
                    r.status = ST_DIVZ;
                    return r;
                end
                re = trunc_div(ar * br + ai * bi, den);
                im = trunc_div(ai * br - ar * bi, den);
            end
        endcase
        r.result_real = clamp_word(re, sat);
        r.result_imag = clamp_word(im, sat);
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        t_cau_out want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result",
                                {o_result.result_real, o_result.result_imag}, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_result.result_real !== want.result_real)
                    report_mismatch("result_real", 64'(o_result.result_real),
                                    64'(want.result_real));
                if (o_result.result_imag !== want.result_imag)
                    report_mismatch("result_imag", 64'(o_result.result_imag),
                                    64'(want.result_imag));
                if (o_result.status !== want.status)
                    report_mismatch("status", 64'(o_result.status), 64'(want.status));
            end
        end
    end

    // Start stays high across back-to-back transactions and drops only for idle cycles.
    task automatic send_item(input t_cau_in x, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in <= x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_results.push_back(complex_result(x));
    endtask

    function automatic logic [DATA_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            1: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            2: return '0;
            3: return DATA_WIDTH'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return DATA_WIDTH'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [DATA_WIDTH-1:0] ext[4];
        t_cau_in x;
        ext = '{{1'b0, {(DATA_WIDTH-1){1'b1}}}, {1'b1, {(DATA_WIDTH-1){1'b0}}},
                '0, {DATA_WIDTH{1'b1}}};
        for (int op = 0; op < 4; op++) begin
            for (int k = 0; k < 4; k++) begin
                x.operation = op[1:0];
                x.a_real = ext[k];
                x.a_imag = ext[3 - k];
                x.b_real = ext[(k + 1) % 4];
                x.b_imag = ext[(k + 2) % 4];
                send_item(x, 0);
            end
        end
        // Division by zero, exact unit values and the extreme divisor.
        x = '{OP_DIV, 32'sd65536, -32'sd65536, 32'sd0, 32'sd0};
        send_item(x, 1);
        x = '{OP_DIV, 32'sd65536, 32'sd0, 32'sd65536, 32'sd0};
        send_item(x, 0);
        x = '{OP_MUL, 32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536};
        send_item(x, 0);
        x = '{OP_DIV, ext[0], ext[1], 32'sd1, 32'sd0};
        send_item(x, 0);
        x = '{OP_DIV, 32'sd1, 32'sd0, ext[1], ext[1]};
        send_item(x, 0);
    endtask

    task automatic test_random();
        t_cau_in x;
        int gap;
        for (int n = 0; n < 1330; n++) begin
            x.operation = 2'($urandom_range(0, 3));
            x.a_real = rand_word();
            x.a_imag = rand_word();
            x.b_real = rand_word();
            x.b_imag = rand_word();
            // Long stretches of back-to-back transactions between idle bursts.
            gap = ((n / 100) % 3 == 0) ? 0 : int'($urandom_range(0, 14));
            send_item(x, gap);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
